>>> src/upk_pkg.sv
// ----------------------------------------------------------------------------
// upk_pkg
// shared widths, register indexes and beat types of the packed bit-field
// unpacker
// ----------------------------------------------------------------------------
package upk_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 10;
   localparam int POS_W       = 16;
   localparam int VALUE_W     = 64;
   localparam int WIDTH_W     = 7;
   localparam int BIT_CNT_W   = 4;
   localparam int RUN_CMP_W   = 13;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // limits
   localparam int MAX_RUN_DEFAULT = 512;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd1;

   // register indexes (decoded from paddr[2])
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_ZIGZAG = 1'b1;

   // configuration seen by the datapath
   typedef struct packed {
      logic [WIDTH_W-1:0] eff_width;
      logic               zigzag;
   } cfg_type;

   // one completed value travelling to the output stage
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               last;
   } beat_type;

endpackage

>>> src/upk_csr.sv
// ----------------------------------------------------------------------------
// upk_csr
// configuration registers behind a small apb-style port
// ----------------------------------------------------------------------------
module upk_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [upk_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [upk_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [upk_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output upk_pkg::cfg_type                cfg
);
   import upk_pkg::*;

   logic [WIDTH_W-1:0] width_ff, width_in;
   logic               zigzag_ff, zigzag_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes
   always_comb begin
      width_in  = width_ff;
      zigzag_in = zigzag_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            CSR_IDX_WIDTH:  width_in  = csr_pwdata[WIDTH_W-1:0];
            CSR_IDX_ZIGZAG: zigzag_in = csr_pwdata[0];
            default:        width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         zigzag_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         zigzag_ff <= zigzag_in;
      end
   end

   // read back
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_WIDTH:  csr_prdata = {{(CSR_DATA_W-WIDTH_W){1'b0}}, width_ff};
         CSR_IDX_ZIGZAG: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, zigzag_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // width of zero acts as one, above the maximum as the maximum
   always_comb begin
      if (width_ff == '0)
         cfg.eff_width = WIDTH_W'(1);
      else if (width_ff > WIDTH_MAX)
         cfg.eff_width = WIDTH_MAX;
      else
         cfg.eff_width = width_ff;
      cfg.zigzag = zigzag_ff;
   end

endmodule

>>> src/upk_bit_eng.sv
// ----------------------------------------------------------------------------
// upk_bit_eng
// bit-serial unpack engine: shifts one bit per cycle, while the output stage has room,
// out of the byte register into the value shift register and counts bits and values of the run
// ----------------------------------------------------------------------------
module upk_bit_eng #(
   parameter int MAX_RUN = upk_pkg::MAX_RUN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  upk_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [upk_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          run_start,
   input  logic [upk_pkg::COUNT_W-1:0]   run_count,
   input  logic [upk_pkg::POS_W-1:0]     run_offset,
   output logic                          emit,
   output upk_pkg::beat_type             beat,
   input  logic                          out_ready
);
   import upk_pkg::*;

   localparam int LEFT_W = $clog2(MAX_RUN + 1);

   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [BIT_CNT_W-1:0] bits_left_ff, bits_left_in;
   logic [VALUE_W-1:0]   partial_ff, partial_in;
   logic [WIDTH_W-1:0]   need_ff, need_in;
   logic [LEFT_W-1:0]    values_left_ff, values_left_in;
   logic [POS_W-1:0]     pos_ff, pos_in;

   logic                 active, live, done, step, accept;
   logic [WIDTH_W-1:0]   need_cur, need_dec;
   logic [VALUE_W-1:0]   partial_shift;
   logic [RUN_CMP_W-1:0] count_ext;
   logic [LEFT_W-1:0]    count_sat;

   // current bit and value bookkeeping
   always_comb begin
      active        = bits_left_ff != '0;
      live          = values_left_ff != '0;
      need_cur      = (need_ff == '0) ? cfg.eff_width : need_ff;
      need_dec      = need_cur - WIDTH_W'(1);
      done          = need_dec == '0;
      partial_shift = (need_ff == '0) ? {{(VALUE_W-1){1'b0}}, byte_ff[BYTE_W-1]}
                                      : {partial_ff[VALUE_W-2:0], byte_ff[BYTE_W-1]};
      step          = active && live && !(done && !out_ready);
      emit          = step && done;
      in_ready      = !active || !live ||
                      (step && bits_left_ff == BIT_CNT_W'(1));
      accept        = in_valid && in_ready;
   end

   // run count saturates to the largest run
   always_comb begin
      count_ext = {{(RUN_CMP_W-COUNT_W){1'b0}}, run_count};
      if (count_ext > RUN_CMP_W'(MAX_RUN))
         count_sat = LEFT_W'(MAX_RUN);
      else
         count_sat = LEFT_W'(count_ext);
   end

   // completed value beat
   always_comb begin
      beat.value    = partial_shift;
      beat.position = pos_ff;
      beat.last     = values_left_ff == LEFT_W'(1);
   end

   // next state: bit step first, a new beat overrides
   always_comb begin
      byte_in        = byte_ff;
      bits_left_in   = bits_left_ff;
      partial_in     = partial_ff;
      need_in        = need_ff;
      values_left_in = values_left_ff;
      pos_in         = pos_ff;

      if (active && !live) begin
         // run exhausted, leftover bits dropped
         bits_left_in = '0;
      end else if (step) begin
         byte_in      = {byte_ff[BYTE_W-2:0], 1'b0};
         bits_left_in = bits_left_ff - BIT_CNT_W'(1);
         partial_in   = partial_shift;
         need_in      = need_dec;
         if (done) begin
            values_left_in = values_left_ff - LEFT_W'(1);
            pos_in         = pos_ff + POS_W'(1);
            if (values_left_ff == LEFT_W'(1))
               bits_left_in = '0;
         end
      end

      if (accept) begin
         byte_in      = data_byte;
         bits_left_in = BIT_CNT_W'(BYTE_W);
         if (run_start) begin
            values_left_in = count_sat;
            pos_in         = run_offset;
            need_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff   <= '0;
         need_ff        <= '0;
         values_left_ff <= '0;
         pos_ff         <= '0;
      end else begin
         bits_left_ff   <= bits_left_in;
         need_ff        <= need_in;
         values_left_ff <= values_left_in;
         pos_ff         <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      partial_ff <= partial_in;
   end

   // checks
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_ready)
      else $error("value completed with no room in the output stage");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= BIT_CNT_W'(BYTE_W))
      else $error("bit counter beyond a byte");

   a_run_range: assert property (@(posedge clock) disable iff (reset)
      values_left_ff <= LEFT_W'(MAX_RUN))
      else $error("value count beyond the longest run");

   a_need_range: assert property (@(posedge clock) disable iff (reset)
      need_ff < WIDTH_MAX)
      else $error("missing bit count beyond the widest value");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      emit && !accept |=> values_left_ff == $past(values_left_ff) - LEFT_W'(1))
      else $error("value count not stepped on a completed value");

endmodule

>>> src/upk_out_stage.sv
// ----------------------------------------------------------------------------
// upk_out_stage
// optional zigzag decode and the result register of the output channel
// ----------------------------------------------------------------------------
module upk_out_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               zigzag,
   input  logic                               emit,
   input  upk_pkg::beat_type                  beat,
   output logic                               out_ready,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [upk_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import upk_pkg::*;

   logic               valid_ff, valid_in;
   beat_type           hold_ff, hold_in;
   logic [VALUE_W-1:0] decoded;

   assign out_ready = !valid_ff || rsp_tready;

   // zigzag: shift right and flip all bits when the low bit is set
   always_comb begin
      if (zigzag)
         decoded = {1'b0, beat.value[VALUE_W-1:1]} ^ {VALUE_W{beat.value[0]}};
      else
         decoded = beat.value;
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      hold_in  = hold_ff;
      if (emit) begin
         valid_in       = 1'b1;
         hold_in        = beat;
         hold_in.value  = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {hold_ff.position, hold_ff.value};
   assign rsp_tlast  = hold_ff.last;

endmodule

>>> src/packed_bit_field_unpacker.sv
// ----------------------------------------------------------------------------
// packed_bit_field_unpacker
// unpacks msb-first bit-packed integers of a configured width from bytes
// ----------------------------------------------------------------------------
// Bytes enter on the req_ stream, one per beat; req_tuser marks the first byte
// of a run, which loads the value count and the start position and drops any
// bits left over. Each value of value_width bits (1..64) that completes leaves
// on the rsp_ stream with its position; rsp_tlast marks the run's final value.
// The csr_ port holds value_width (offset 0) and zigzag_enable (offset 4); the user
// must write them only while the block is idle, which the block does not enforce.
// A byte is shifted out one bit per cycle while the output stage has room, and
// a new byte is taken in the cycle of the last bit; the byte rate is set by the
// bit-serial shift path.
// A value completed by a bit appears on rsp_tvalid in the next cycle, through a
// single result register. If that register is still full when the next value
// completes, the bit engine holds until rsp_tready, and req_tready falls too.
// Bytes beyond the run's count give no beat and are accepted without being shifted out.
// Reset is synchronous: value_width goes to 1, zigzag off, the run count to zero,
// and no beat is pending.
// ----------------------------------------------------------------------------
module packed_bit_field_unpacker #(
   parameter int MAX_RUN = upk_pkg::MAX_RUN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // data_byte [7:0], run_count [17:8], run_offset [33:18], zero [39:34]
   input  logic [upk_pkg::REQ_DATA_W-1:0]    req_tdata,
   // run_start
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // value [63:0], position [79:64]
   output logic [upk_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [upk_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [upk_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [upk_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import upk_pkg::*;

   cfg_type  cfg;
   beat_type beat;
   logic     emit;
   logic     out_ready;

   // configuration registers
   upk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // bit-serial engine
   upk_bit_eng #(
      .MAX_RUN (MAX_RUN)
   ) u_bit_eng (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .data_byte  (req_tdata[BYTE_W-1:0]),
      .run_start  (req_tuser),
      .run_count  (req_tdata[BYTE_W+COUNT_W-1:BYTE_W]),
      .run_offset (req_tdata[BYTE_W+COUNT_W+POS_W-1:BYTE_W+COUNT_W]),
      .emit       (emit),
      .beat       (beat),
      .out_ready  (out_ready)
   );

   // result register
   upk_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .zigzag     (cfg.zigzag),
      .emit       (emit),
      .beat       (beat),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
